FILE: hw/rtl/frame_bitmap_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame bitmap allocator
// Shared short forms for concurrent checks, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_CORE_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define FBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame allocator check failed");

// Consequent checked in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame allocator check failed");

`endif

FILE: hw/rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Types and fixed constants of the frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

   localparam int FRAME_W  = 12;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 13;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED = 3'd0,
      ST_HAD_FRAME = 3'd1,
      ST_NO_FREE   = 3'd2,
      ST_FREED     = 3'd3,
      ST_NOTHING   = 3'd4
   } fba_status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE
   } fba_state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/fba_first_zero.sv
// ----------------------------------------------------------------------------
// fba_first_zero
// Priority encoder: position of the lowest clear bit of a bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_first_zero #(
   parameter int WORD_BITS = 32,
   parameter int IDX_W     = $clog2(WORD_BITS)
) (
   input  wire logic [WORD_BITS-1:0] word,
   output logic                      found,
   output logic [IDX_W-1:0]          index
);

   // scan from the top so the lowest clear bit wins
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            found = 1'b1;
            index = IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core
// First-fit physical page-frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// Usage and timing. After reset the block clears its bitmap memory, all
// MAX_FRAMES / MAP_WORD_BITS words (128 with the defaults), one word a cycle,
// and holds busy high meanwhile; csr writes are taken throughout. An item is
// taken when start is high and busy is low. Items that need no bitmap access
// (allocate for a page that already has a frame, free of frame 0, free of a
// frame beyond the map, allocate with an empty scan range) give their result
// on the next cycle and leave busy low. A free that touches the map reads the
// word, then writes it back. An allocate scan reads one bitmap word per cycle
// through the single read port of the memory, from word 0 up to limit, the
// number of whole words below frame_count, capped at the map depth; it stops
// at the first word with a clear bit, or reports a full map after the last
// word. The result strobe rsp_valid lasts one cycle and cannot be held off,
// so the receiver must take it then.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_core
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES    = 4096,
   parameter int MAP_WORD_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_opcode,
   input  wire logic [FRAME_W-1:0]  req_current_frame,
   input  wire logic                req_is_kernel,
   input  wire logic                req_is_writeable,
   // response
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [FRAME_W-1:0]       rsp_frame_out,
   output logic                     rsp_present_bit,
   output logic                     rsp_writable_bit,
   output logic                     rsp_user_bit,
   // configuration
   input  wire logic                csr_wr_en,
   input  wire logic [COUNT_W-1:0]  csr_wr_data
);

   // MAP_WORD_BITS is taken as a power of two; MAX_FRAMES a multiple of it.
   localparam int MAP_WORDS = MAX_FRAMES / MAP_WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAP_WORDS + 1);
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int FULL_W    = AW + BIT_W;
   localparam int EXT_W     = (FULL_W > FRAME_W) ? FULL_W : FRAME_W;

   // control state
   fba_state_type              state_ff, state_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [COUNT_W-1:0]         count_ff;
   // per-item payload
   logic [CNT_W-1:0]           limit_ff, limit_in;
   logic [BIT_W-1:0]           bit_ff, bit_in;
   logic                       kern_ff, kern_in;
   logic                       wrt_ff, wrt_in;
   // bitmap memory
   logic [MAP_WORD_BITS-1:0]   map_mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0]   rd_data_ff;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [MAP_WORD_BITS-1:0]   wr_data;
   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   fba_status_type             rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0]         rsp_frame_ff, rsp_frame_in;
   logic                       rsp_present_ff, rsp_present_in;
   logic                       rsp_writable_ff, rsp_writable_in;
   logic                       rsp_user_ff, rsp_user_in;

   // decode of the incoming item
   logic                       accept;
   logic                       cur_zero;
   logic                       cur_in_map;
   logic [AW-1:0]              cur_word;
   logic [BIT_W-1:0]           cur_bit;
   logic [COUNT_W-1:0]         words_raw;
   logic [CNT_W-1:0]           scan_limit;

   // scan datapath
   logic                       zero_found;
   logic [BIT_W-1:0]           zero_idx;
   logic                       scan_last;
   logic [FULL_W-1:0]          frame_full;
   logic [EXT_W-1:0]           frame_ext;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign cur_zero = (req_current_frame == '0);

   // frames at or above MAX_FRAMES leave the map alone on a free
   assign cur_in_map = (32'(req_current_frame) < MAX_FRAMES);
   assign cur_word   = AW'(32'(req_current_frame) >> BIT_W);
   assign cur_bit    = req_current_frame[BIT_W-1:0];

   // whole words below frame_count, saturated at the map depth
   assign words_raw  = count_ff >> BIT_W;
   assign scan_limit = (32'(words_raw) > MAP_WORDS) ? CNT_W'(MAP_WORDS)
                                                    : CNT_W'(words_raw);

   fba_first_zero #(
      .WORD_BITS (MAP_WORD_BITS),
      .IDX_W     (BIT_W)
   ) u_first_zero (
      .word  (rd_data_ff),
      .found (zero_found),
      .index (zero_idx)
   );

   assign scan_last  = ((CNT_W'(addr_ff) + CNT_W'(1)) == limit_ff);
   assign frame_full = {addr_ff, zero_idx};
   assign frame_ext  = EXT_W'(frame_full);  // wider frames keep their low bits

   // next state and per-item registers
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      limit_in = limit_ff;
      bit_in   = bit_ff;
      kern_in  = kern_ff;
      wrt_in   = wrt_ff;
      unique case (state_ff)
         S_CLEAR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
               addr_in  = '0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               kern_in = req_is_kernel;
               wrt_in  = req_is_writeable;
               priority if (req_opcode == OP_ALLOC && cur_zero
                            && scan_limit != '0) begin
                  state_in = S_SCAN;
                  addr_in  = '0;
                  limit_in = scan_limit;
               end else if (req_opcode == OP_FREE && !cur_zero && cur_in_map) begin
                  state_in = S_FREE;
                  addr_in  = cur_word;
                  bit_in   = cur_bit;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            // word at addr_ff is in rd_data_ff; next read already issued
            priority if (zero_found || scan_last) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_FREE: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory writes and response
   always_comb begin
      wr_en           = 1'b0;
      wr_addr         = addr_ff;
      wr_data         = '0;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = ST_ALLOCATED;
      rsp_frame_in    = '0;
      rsp_present_in  = 1'b0;
      rsp_writable_in = 1'b0;
      rsp_user_in     = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               priority if (req_opcode == OP_ALLOC && !cur_zero) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_HAD_FRAME;
                  rsp_frame_in  = req_current_frame;
               end else if (req_opcode == OP_ALLOC && scan_limit == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_FREE;
               end else if (req_opcode == OP_FREE && cur_zero) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOTHING;
               end else if (req_opcode == OP_FREE && !cur_in_map) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FREED;
               end else begin
                  rsp_valid_in  = 1'b0;
               end
            end
         end
         S_SCAN: begin
            priority if (zero_found) begin
               wr_en           = 1'b1;
               wr_data         = rd_data_ff | (MAP_WORD_BITS'(1) << zero_idx);
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_ALLOCATED;
               rsp_frame_in    = frame_ext[FRAME_W-1:0];
               rsp_present_in  = 1'b1;
               rsp_writable_in = wrt_ff;
               rsp_user_in     = !kern_ff;
            end else if (scan_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NO_FREE;
            end else begin
               rsp_valid_in  = 1'b0;
            end
         end
         S_FREE: begin
            wr_en         = 1'b1;
            wr_data       = rd_data_ff & ~(MAP_WORD_BITS'(1) << bit_ff);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FREED;
         end
      endcase
   end

   // bitmap memory: one write, one registered read at the next address.
   // A write-back always ends an item, so the next item's first read is issued
   // from S_IDLE, after the write, and sees it.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[addr_in];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      limit_ff        <= limit_in;
      bit_ff          <= bit_in;
      kern_ff         <= kern_in;
      wrt_ff          <= wrt_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_writable_ff <= rsp_writable_in;
      rsp_user_ff     <= rsp_user_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_out    = rsp_frame_ff;
   assign rsp_present_bit  = rsp_present_ff;
   assign rsp_writable_bit = rsp_writable_ff;
   assign rsp_user_bit     = rsp_user_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fba_checker.sv
// ----------------------------------------------------------------------------
// fba_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_bitmap_allocator_core_assert.svh"

module fba_checker
   import fba_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                req_opcode,
   input wire logic [FRAME_W-1:0]  req_current_frame,
   input wire logic                rsp_valid,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [FRAME_W-1:0]  rsp_frame_out,
   input wire logic                rsp_present_bit,
   input wire logic                rsp_writable_bit,
   input wire logic                rsp_user_bit
);

   logic alloc_had;
   logic alloc_new;
   logic free_none;
   logic flags_clear;

   assign alloc_had = !reset && start && !busy && req_opcode == OP_ALLOC
                      && req_current_frame != '0;
   assign alloc_new = !reset && start && !busy && req_opcode == OP_ALLOC
                      && req_current_frame == '0;
   assign free_none = !reset && start && !busy && req_opcode == OP_FREE
                      && req_current_frame == '0;
   assign flags_clear = !rsp_present_bit && !rsp_writable_bit && !rsp_user_bit;

   // page that already has a frame: answered at once, frame echoed
   `FBA_ASSERT_NEXT(a_had_frame, clock, reset, alloc_had, rsp_valid && rsp_status == ST_HAD_FRAME && rsp_frame_out == $past(req_current_frame))

   // free of frame 0: answered at once
   `FBA_ASSERT_NEXT(a_free_none, clock, reset, free_none, rsp_valid && rsp_status == ST_NOTHING && rsp_frame_out == '0)

   // a scan starts, or an empty range is reported straight away
   `FBA_ASSERT_NEXT(a_alloc_scan, clock, reset, alloc_new, busy || (rsp_valid && rsp_status == ST_NO_FREE))

   // page-entry flags only accompany a successful allocation
   `FBA_ASSERT_SAME(a_flags, clock, reset, rsp_valid && rsp_status != ST_ALLOCATED, flags_clear)

endmodule

bind frame_bitmap_allocator_core fba_checker u_fba_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_opcode        (req_opcode),
   .req_current_frame (req_current_frame),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_frame_out     (rsp_frame_out),
   .rsp_present_bit   (rsp_present_bit),
   .rsp_writable_bit  (rsp_writable_bit),
   .rsp_user_bit      (rsp_user_bit)
);

`default_nettype wire

FILE: tb/frame_bitmap_allocator_checker.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_checker
// Watches the request, response and csr ports of the frame allocator. It keeps
// its own copy of the frame bitmap, predicts each response and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_checker
   import fba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic                req_opcode,
   input  wire logic [FRAME_W-1:0]  req_current_frame,
   input  wire logic                req_is_kernel,
   input  wire logic                req_is_writeable,
   input  wire logic                rsp_valid,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic [FRAME_W-1:0]  rsp_frame_out,
   input  wire logic                rsp_present_bit,
   input  wire logic                rsp_writable_bit,
   input  wire logic                rsp_user_bit,
   input  wire logic                csr_wr_en,
   input  wire logic [COUNT_W-1:0]  csr_wr_data,
   output int                       fail_count,
   output int                       outstanding,
   output int                       checked_count,
   output int                       full_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_BITS = 32;
   localparam int MAP_WORDS = 4096 / WORD_BITS;
   localparam int MAX_PRINTS = 50;

   typedef struct packed {
      fba_status_type     status;
      logic [FRAME_W-1:0] frame;
      logic               present;
      logic               writable;
      logic               user;
   } page_entry_type;

   logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
   logic [COUNT_W-1:0]   managed_frames;
   page_entry_type       entries_due[$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      checked_count = 0;
      full_count    = 0;
   end

   // First-fit allocate or free against the local bitmap copy.
   function automatic page_entry_type service_request(input logic op,
                                                      input logic [FRAME_W-1:0] cur,
                                                      input logic kern,
                                                      input logic wr);
      page_entry_type e;
      int             words;
      int             found;
      e = '0;
      if (op == OP_ALLOC) begin
         if (cur != '0) begin
            e.status = ST_HAD_FRAME;
            e.frame  = cur;
         end else begin
            // only whole words below the count, capped at the map depth
            words = int'(managed_frames) / WORD_BITS;
            if (words > MAP_WORDS) words = MAP_WORDS;
            found = -1;
            for (int w = 0; w < words && found < 0; w++)
               for (int b = 0; b < WORD_BITS && found < 0; b++)
                  if (!frame_map[w][b]) found = w * WORD_BITS + b;
            if (found >= 0) begin
               frame_map[found / WORD_BITS][found % WORD_BITS] = 1'b1;
               e.status   = ST_ALLOCATED;
               e.frame    = found[FRAME_W-1:0];
               e.present  = 1'b1;
               e.writable = wr;
               e.user     = ~kern;
            end else begin
               e.status = ST_NO_FREE;
            end
         end
      end else begin
         if (cur == '0) begin
            e.status = ST_NOTHING;
         end else begin
            // 12-bit frame always lies inside the map
            frame_map[cur[FRAME_W-1:5]][cur[4:0]] = 1'b0;
            e.status = ST_FREED;
         end
      end
      return e;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      page_entry_type want;
      if (reset) begin
         foreach (frame_map[i]) frame_map[i] = '0;
         managed_frames = COUNT_RESET;
         entries_due.delete();
      end else begin
         if (rsp_valid) begin
            if (entries_due.size() == 0) begin
               report_mismatch("response with no item due", rsp_status, -1);
            end else begin
               want = entries_due.pop_front();
               checked_count++;
               if (want.status == ST_NO_FREE) full_count++;
               if (rsp_status != want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_frame_out != want.frame)
                  report_mismatch("frame_out", rsp_frame_out, want.frame);
               if (rsp_present_bit != want.present)
                  report_mismatch("present_bit", rsp_present_bit, want.present);
               if (rsp_writable_bit != want.writable)
                  report_mismatch("writable_bit", rsp_writable_bit, want.writable);
               if (rsp_user_bit != want.user)
                  report_mismatch("user_bit", rsp_user_bit, want.user);
            end
         end
         // an item taken at this edge still sees the old count
         if (start && !busy)
            entries_due.push_back(service_request(req_opcode, req_current_frame,
                                                  req_is_kernel, req_is_writeable));
         if (csr_wr_en) managed_frames = csr_wr_data;
      end
      outstanding <= entries_due.size();
   end

endmodule

`default_nettype wire

FILE: tb/tb_frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_frame_bitmap_allocator_core
// Drives allocate and free items into the frame allocator over a range of
// frame_count settings and sender idling, with a checker alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_frame_bitmap_allocator_core
   import fba_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_PHASES       = 8;
   localparam int PHASE_ITEMS    = 148;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int TAIL_CYCLES    = 140;     // covers the longest full-map scan
   localparam int MAX_FRAME      = 4095;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                start             = 1'b0;
   logic                busy;
   logic                req_opcode        = OP_ALLOC;
   logic [FRAME_W-1:0]  req_current_frame = '0;
   logic                req_is_kernel     = 1'b0;
   logic                req_is_writeable  = 1'b0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [FRAME_W-1:0]  rsp_frame_out;
   logic                rsp_present_bit;
   logic                rsp_writable_bit;
   logic                rsp_user_bit;
   logic                csr_wr_en         = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data       = '0;

   int fail_count;
   int outstanding;
   int checked_count;
   int full_count;

   int cycle_count = 0;
   int items_sent  = 0;
   int idle_pct    = 0;     // chance in a hundred that the sender idles a cycle
   int frame_span  = 512;   // upper bound for frees aimed at frames likely in use

   logic [COUNT_W-1:0] phase_counts [N_PHASES];

   frame_bitmap_allocator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_current_frame (req_current_frame),
      .req_is_kernel     (req_is_kernel),
      .req_is_writeable  (req_is_writeable),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_frame_out     (rsp_frame_out),
      .rsp_present_bit   (rsp_present_bit),
      .rsp_writable_bit  (rsp_writable_bit),
      .rsp_user_bit      (rsp_user_bit),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   frame_bitmap_allocator_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_current_frame (req_current_frame),
      .req_is_kernel     (req_is_kernel),
      .req_is_writeable  (req_is_writeable),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_frame_out     (rsp_frame_out),
      .rsp_present_bit   (rsp_present_bit),
      .rsp_writable_bit  (rsp_writable_bit),
      .rsp_user_bit      (rsp_user_bit),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .checked_count     (checked_count),
      .full_count        (full_count)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count, outstanding);
         $display("FAIL frame_bitmap_allocator_core");
         $finish;
      end
   end

   // One item: optional idle gap, then hold start until an edge sees busy low.
   // start stays high on return so back-to-back items keep it up.
   task automatic send_item(input logic op, input logic [FRAME_W-1:0] cur,
                            input logic kern, input logic wr);
      int gap;
      gap = 0;
      if (idle_pct > 0)
         while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= op;
      req_current_frame <= cur;
      req_is_kernel     <= kern;
      req_is_writeable  <= wr;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Stop sending and wait until every item has answered and busy is low.
   task automatic drain_then_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // frame_count is only changed with the block idle
   task automatic write_frame_count(input logic [COUNT_W-1:0] value);
      drain_then_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (value < 32)       frame_span = 32;
      else if (value > 512) frame_span = 512;
      else                  frame_span = int'(value);
   endtask

   // Mix of allocates, re-allocates, frees of live frames and stray frees.
   task automatic send_random_item();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         send_item(OP_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (roll < 65)
         send_item(OP_ALLOC, FRAME_W'($urandom_range(1, MAX_FRAME)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (roll < 90)
         send_item(OP_FREE, FRAME_W'($urandom_range(1, frame_span - 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (roll < 95)
         send_item(OP_FREE, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
         send_item(OP_FREE, FRAME_W'($urandom_range(1, MAX_FRAME)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      // small counts fill the map quickly, zero and below a word give an empty
      // scan, the top value saturates at the map depth
      phase_counts = '{13'd64, 13'd8191, 13'd32, 13'd0,
                       13'd4096, 13'd96, 13'd31, 13'd0};
      phase_counts[N_PHASES-1] = COUNT_W'($urandom_range(0, int'(COUNT_MAX)));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed items, reset frame_count ----
      idle_pct = 0;
      // frame zero is handed out first, then every flag pairing
      send_item(OP_ALLOC, '0, 1'b0, 1'b0);
      send_item(OP_ALLOC, '0, 1'b0, 1'b1);
      send_item(OP_ALLOC, '0, 1'b1, 1'b0);
      send_item(OP_ALLOC, '0, 1'b1, 1'b1);
      // page already holds a frame: nothing changes
      send_item(OP_ALLOC, 12'hFFF, 1'b1, 1'b1);
      send_item(OP_ALLOC, 12'd1, 1'b0, 1'b0);
      // nothing to free
      send_item(OP_FREE, '0, 1'b1, 1'b1);
      // free of a frame never handed out
      send_item(OP_FREE, 12'hFFF, 1'b0, 1'b0);
      // free a live frame, then the allocate reuses it
      send_item(OP_FREE, 12'd2, 1'b0, 1'b1);
      send_item(OP_ALLOC, '0, 1'b0, 1'b1);
      // empty scan range: map reported full
      write_frame_count('0);
      send_item(OP_ALLOC, '0, 1'b0, 1'b0);
      write_frame_count(13'd31);
      send_item(OP_ALLOC, '0, 1'b1, 1'b1);
      // count far above the map saturates
      write_frame_count(COUNT_MAX);
      send_item(OP_ALLOC, '0, 1'b1, 1'b0);
      send_item(OP_FREE, 12'd4, 1'b1, 1'b1);

      // ---- random phases ----
      for (int p = 0; p < N_PHASES; p++) begin
         write_frame_count(phase_counts[p]);
         case (p % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 52;
            default: idle_pct = 38;
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_item();
            // now and then let the block drain completely
            if ($urandom_range(0, 59) == 0) drain_then_idle();
         end
      end

      // ---- wind down ----
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items across %0d frame_count settings, idle and back to back.",
               items_sent, N_PHASES + 4);
      $display("Checked %0d responses, %0d of them map-full refusals, %0d mismatches.",
               checked_count, full_count, fail_count);
      if (fail_count == 0) begin
         $display("PASS frame_bitmap_allocator_core");
      end else begin
         $display("FAIL frame_bitmap_allocator_core");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/fba_pkg.sv
hw/rtl/fba_first_zero.sv
hw/rtl/frame_bitmap_allocator_core.sv
hw/rtl/fba_checker.sv
tb/frame_bitmap_allocator_checker.sv
tb/tb_frame_bitmap_allocator_core.sv
